>>> rtl/core/lpbg_pkg.sv
package lpbg_pkg;

	// configuration port
	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 16;

	typedef enum logic [CfgIndexW-1:0] {
		REG_SYNC_LEGS    = 3'd0,
		REG_COLOR_MODE   = 3'd1,
		REG_STATIC_HUE   = 3'd2,
		REG_STATIC_SAT   = 3'd3,
		REG_MIN_PULSE_MS = 3'd4,
		REG_MAX_PULSE_MS = 3'd5
	} cfg_reg_e;

	typedef enum logic [1:0] {
		COLOR_STATIC = 2'd0,
		COLOR_CYCLE  = 2'd1,
		COLOR_RANDOM = 2'd2
	} color_mode_e;

	// register reset values
	localparam logic [7:0]  StaticSatReset = 8'd255;
	localparam logic [15:0] MinPulseReset  = 16'd500;
	localparam logic [15:0] MaxPulseReset  = 16'd1500;

	// brightness curve
	localparam int PctFloor  = 25;
	localparam int PctFull   = 100;
	localparam int RampSpan  = PctFull - PctFloor;
	localparam int CubeGain  = 256;
	localparam int CubeScale = 1000000;
	localparam int BrightMax = 255;
	localparam int PctW      = 7;
	localparam int LutDepth  = 1 << PctW;

	localparam logic [7:0] HueStep = 8'd3;
	localparam logic [7:0] HueTop  = 8'd255;

	// shared divider
	localparam int DivNW = 24;
	localparam int DivDW = 16;

	localparam int QueueDepth = 2;

	typedef enum logic {
		KIND_FRAME = 1'b0,
		KIND_SYNC  = 1'b1
	} kind_e;

	typedef struct packed {
		logic        op;
		logic [31:0] now_ms;
		logic [15:0] rand_len;
		logic [7:0]  rand_hue;
		logic [15:0] sync_length;
		logic [15:0] sync_level;
		logic        sync_change_color;
		logic        sync_dimming;
	} in_item_t;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
		logic       falling;
	} out_item_t;

	typedef struct packed {
		kind_e       kind;
		logic [31:0] now_ms;
		logic [15:0] rand_len;
		logic [7:0]  rand_hue;
		logic [15:0] sync_length;
		logic [15:0] sync_level;
		logic        sync_change_color;
		logic        sync_dimming;
	} q_entry_t;

	typedef struct packed {
		logic        sync_legs;
		logic [1:0]  color_mode;
		logic [7:0]  static_hue;
		logic [7:0]  static_sat;
		logic [15:0] min_pulse_ms;
		logic [15:0] max_pulse_ms;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DivNW-1:0] dividend;
		logic [DivDW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DivNW-1:0] quotient;
		logic [DivDW-1:0] remainder;
	} div_resp_t;

	typedef logic [7:0] curve_lut_t [LutDepth];

	// floor(p^3 * 256 / 10^6) saturated, built at elaboration
	function automatic curve_lut_t build_curve_lut();
		curve_lut_t  lut;
		int unsigned cube;
		for (int p = 0; p < LutDepth; p++) begin
			cube = (p * p * p * CubeGain) / CubeScale;
			lut[p] = (cube > BrightMax) ? 8'(BrightMax) : 8'(cube);
		end
		return lut;
	endfunction

endpackage

>>> rtl/core/led_pulse_brightness_generator_top.sv
// led breathing pulse generator: each frame beat (op 0) advances a slow pulse and
// yields one colour beat (hue, saturation, cubic brightness, falling flag); a sync
// beat (op 1) only loads the sync length, level and flags and yields nothing. beats
// pass a one-stage front end into a short queue, so the input keeps taking beats
// while the back end works, until the queue is full. a frame's time in the back end
// is set by one shared 24-step serial divider, used once for the drawn pulse length
// at the start of a free-running pulse and once for the ramp percentage while the
// ramp value is below the pulse length. registers are written on the cfg channel
// (always ready); the user must write them only while idle; the block does not check.
module led_pulse_brightness_generator_top #(
	parameter int QUEUE_DEPTH = lpbg_pkg::QueueDepth
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input beats
	input  logic                               item_valid,
	output logic                               item_stall,
	input  lpbg_pkg::in_item_t                 item,
	// result beats
	output logic                               result_valid,
	input  logic                               result_stall,
	output lpbg_pkg::out_item_t                result,
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lpbg_pkg::CfgIndexW-1:0]     cfg_index,
	input  logic [lpbg_pkg::CfgDataW-1:0]      cfg_data
);
	import lpbg_pkg::*;

	cfg_t      cfg_q;
	logic      push_valid;
	logic      push_full;
	q_entry_t  push_entry;
	logic      pop_valid;
	logic      pop;
	q_entry_t  pop_entry;
	div_req_t  div_req;
	div_resp_t div_resp;

	// writes never wait
	assign cfg_ready = 1'b1;

	// register file, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_legs    <= 1'b0;
			cfg_q.color_mode   <= COLOR_STATIC;
			cfg_q.static_hue   <= '0;
			cfg_q.static_sat   <= StaticSatReset;
			cfg_q.min_pulse_ms <= MinPulseReset;
			cfg_q.max_pulse_ms <= MaxPulseReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SYNC_LEGS:    cfg_q.sync_legs    <= cfg_data[0];
				REG_COLOR_MODE:   cfg_q.color_mode   <= cfg_data[1:0];
				REG_STATIC_HUE:   cfg_q.static_hue   <= cfg_data[7:0];
				REG_STATIC_SAT:   cfg_q.static_sat   <= cfg_data[7:0];
				REG_MIN_PULSE_MS: cfg_q.min_pulse_ms <= cfg_data;
				REG_MAX_PULSE_MS: cfg_q.max_pulse_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front end: takes beats and tags them frame or sync
	lpbg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_entry (push_entry)
	);

	// decoupling queue between front and back
	lpbg_queue #(
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_entry  (pop_entry)
	);

	// shared serial divider for length draw and ramp percentage
	lpbg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.resp   (div_resp)
	);

	// back end: pulse timing, colour change, brightness curve, result register
	lpbg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pop_valid    (pop_valid),
		.pop          (pop),
		.pop_entry    (pop_entry),
		.div_req      (div_req),
		.div_resp     (div_resp),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> rtl/core/lpbg_front.sv
module lpbg_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  lpbg_pkg::in_item_t item,
	output logic               push_valid,
	input  logic               push_full,
	output lpbg_pkg::q_entry_t push_entry
);
	import lpbg_pkg::*;

	logic     valid_s1;
	q_entry_t entry_s1;
	logic     accept;

	assign item_stall = valid_s1 && push_full;
	assign accept     = item_valid && !item_stall;
	assign push_valid = valid_s1;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!push_full) begin
			valid_s1 <= 1'b0;
		end
	end

	// classify the beat
	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1.kind              <= item.op ? KIND_SYNC : KIND_FRAME;
			entry_s1.now_ms            <= item.now_ms;
			entry_s1.rand_len          <= item.rand_len;
			entry_s1.rand_hue          <= item.rand_hue;
			entry_s1.sync_length       <= item.sync_length;
			entry_s1.sync_level        <= item.sync_level;
			entry_s1.sync_change_color <= item.sync_change_color;
			entry_s1.sync_dimming      <= item.sync_dimming;
		end
	end

endmodule

>>> rtl/core/lpbg_queue.sv
module lpbg_queue #(
	parameter int Depth = lpbg_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_full,
	input  lpbg_pkg::q_entry_t push_entry,
	output logic               pop_valid,
	input  logic               pop,
	output lpbg_pkg::q_entry_t pop_entry
);
	import lpbg_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	q_entry_t          mem [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_full = (count_q == CntW'(Depth));
	assign pop_valid = (count_q != '0);
	assign pop_entry = mem[rd_ptr_q];
	assign do_push   = push_valid && !push_full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

endmodule

>>> rtl/core/lpbg_div.sv
module lpbg_div (
	input  logic                clk,
	input  logic                arst_n,
	input  lpbg_pkg::div_req_t  req,
	output lpbg_pkg::div_resp_t resp
);
	import lpbg_pkg::*;

	localparam int CntW = $clog2(DivNW + 1);

	logic [DivDW-1:0] rem_q;
	logic [DivNW-1:0] quot_q;
	logic [DivDW-1:0] divisor_q;
	logic [CntW-1:0]  count_q;
	logic             busy_q;
	logic             done_q;
	logic [DivDW:0]   shifted;
	logic [DivDW:0]   diff;

	// one restoring step a cycle, dividend bits shift out as quotient bits shift in
	assign shifted = {rem_q, quot_q[DivNW-1]};
	assign diff    = shifted - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			quot_q    <= '0;
			divisor_q <= '0;
			count_q   <= '0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q     <= '0;
				quot_q    <= req.dividend;
				divisor_q <= req.divisor;
				count_q   <= CntW'(DivNW);
				busy_q    <= 1'b1;
			end else if (busy_q) begin
				if (!diff[DivDW]) begin
					rem_q  <= diff[DivDW-1:0];
					quot_q <= {quot_q[DivNW-2:0], 1'b1};
				end else begin
					rem_q  <= shifted[DivDW-1:0];
					quot_q <= {quot_q[DivNW-2:0], 1'b0};
				end
				count_q <= count_q - 1'b1;
				if (count_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign resp.done      = done_q;
	assign resp.quotient  = quot_q;
	assign resp.remainder = rem_q;

endmodule

>>> rtl/core/lpbg_back.sv
module lpbg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lpbg_pkg::cfg_t      cfg,
	input  logic                pop_valid,
	output logic                pop,
	input  lpbg_pkg::q_entry_t  pop_entry,
	output lpbg_pkg::div_req_t  div_req,
	input  lpbg_pkg::div_resp_t div_resp,
	output logic                result_valid,
	input  logic                result_stall,
	output lpbg_pkg::out_item_t result
);
	import lpbg_pkg::*;

	localparam curve_lut_t CurveLut = build_curve_lut();

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_MOD,
		S_COLOR,
		S_DIV,
		S_LUT
	} state_t;

	state_t      state_q;
	q_entry_t    item_q;
	div_req_t    div_req_q;
	logic        result_valid_q;
	out_item_t   result_q;

	logic [31:0] last_change_q;
	logic [15:0] pulse_len_q;
	logic        dim_q;
	logic        change_q;
	logic [7:0]  cur_hue_q;
	logic [7:0]  cur_sat_q;
	logic        loaded_q;
	logic [15:0] held_len_q;
	logic [15:0] held_level_q;
	logic [31:0] value_q;
	logic [PctW-1:0] pct_q;

	logic [31:0] elapsed;
	logic [16:0] twice;
	logic        new_pulse;
	logic        dim_next;

	assign pop          = (state_q == S_IDLE) && pop_valid;
	assign div_req      = div_req_q;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign elapsed   = item_q.now_ms - last_change_q;
	assign twice     = {pulse_len_q, 1'b0};
	assign new_pulse = (elapsed >= 32'(twice));
	assign dim_next  = dim_q || (elapsed >= 32'(pulse_len_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			item_q         <= '0;
			div_req_q      <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			last_change_q  <= '0;
			pulse_len_q    <= '0;
			dim_q          <= 1'b0;
			change_q       <= 1'b0;
			cur_hue_q      <= '0;
			cur_sat_q      <= '0;
			loaded_q       <= 1'b0;
			held_len_q     <= '0;
			held_level_q   <= '0;
			value_q        <= '0;
			pct_q          <= '0;
		end else begin
			div_req_q.start <= 1'b0;
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						if (pop_entry.kind == KIND_SYNC) begin
							held_len_q   <= pop_entry.sync_length;
							held_level_q <= pop_entry.sync_level;
							change_q     <= pop_entry.sync_change_color;
							dim_q        <= pop_entry.sync_dimming;
						end else begin
							item_q  <= pop_entry;
							state_q <= S_EVAL;
						end
					end
				end

				S_EVAL: begin
					if (!loaded_q) begin
						cur_hue_q <= cfg.static_hue;
						cur_sat_q <= cfg.static_sat;
						loaded_q  <= 1'b1;
					end
					if (cfg.sync_legs) begin
						pulse_len_q <= held_len_q;
						value_q     <= 32'(held_level_q);
						state_q     <= S_COLOR;
					end else if (new_pulse) begin
						last_change_q <= item_q.now_ms;
						dim_q         <= 1'b0;
						change_q      <= 1'b1;
						value_q       <= '0;
						if (cfg.max_pulse_ms > cfg.min_pulse_ms) begin
							div_req_q.start    <= 1'b1;
							div_req_q.dividend <= DivNW'(item_q.rand_len);
							div_req_q.divisor  <= cfg.max_pulse_ms - cfg.min_pulse_ms;
							state_q            <= S_MOD;
						end else begin
							pulse_len_q <= cfg.min_pulse_ms;
							state_q     <= S_COLOR;
						end
					end else begin
						change_q <= 1'b0;
						dim_q    <= dim_next;
						if (dim_next) begin
							value_q <= (32'(twice) > elapsed) ?
								32'(twice - elapsed[16:0]) : '0;
						end else begin
							value_q <= elapsed;
						end
						state_q <= S_COLOR;
					end
				end

				S_MOD: begin
					if (div_resp.done) begin
						pulse_len_q <= cfg.min_pulse_ms + div_resp.remainder;
						state_q     <= S_COLOR;
					end
				end

				S_COLOR: begin
					if (change_q) begin
						case (cfg.color_mode)
							COLOR_STATIC: begin
								cur_hue_q <= cfg.static_hue;
								cur_sat_q <= cfg.static_sat;
							end
							COLOR_CYCLE: begin
								cur_hue_q <= (cur_hue_q == HueTop) ? '0 : cur_hue_q + HueStep;
							end
							COLOR_RANDOM: begin
								cur_hue_q <= item_q.rand_hue;
							end
							default: begin
							end
						endcase
					end
					// value at or past the length always clamps to full
					if (pulse_len_q == '0 || value_q >= 32'(pulse_len_q)) begin
						pct_q   <= PctW'(PctFull);
						state_q <= S_LUT;
					end else begin
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= DivNW'(value_q[15:0] * RampSpan);
						div_req_q.divisor  <= pulse_len_q;
						state_q            <= S_DIV;
					end
				end

				S_DIV: begin
					if (div_resp.done) begin
						pct_q   <= div_resp.quotient[PctW-1:0] + PctW'(PctFloor);
						state_q <= S_LUT;
					end
				end

				S_LUT: begin
					if (!result_valid_q || !result_stall) begin
						result_q.hue        <= cur_hue_q;
						result_q.saturation <= cur_sat_q;
						result_q.brightness <= CurveLut[pct_q];
						result_q.falling    <= dim_q;
						result_valid_q      <= 1'b1;
						state_q             <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
